>>> src/assert_macros.svh
// Assertion macros shared by the BER TLV decoder RTL.
// Every macro samples on clk_i and is quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/btlv_pkg.sv
// Types and constants of the BER TLV primitive decoder.
// Used by the register block, the decode stage and the top level.
`default_nettype none

package btlv_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam logic [CfgAddrW-1:0] REG_EXPECTED_TAG = 4'h0;
  localparam logic [CfgAddrW-1:0] REG_VALUE_KIND   = 4'h4;
  localparam logic [CfgAddrW-1:0] REG_MAX_OCTETS   = 4'h8;

  localparam logic [31:0] EXPECTED_TAG_RESET = 32'd2;
  localparam logic [15:0] MAX_OCTETS_RESET   = 16'd256;

  localparam logic [7:0] CONSTRUCTED_BIT = 8'h20;
  localparam logic [7:0] LONG_FORM_BIT   = 8'h80;
  localparam logic [7:0] LEN_FIELD_MASK  = 8'h7F;
  localparam logic [6:0] MAX_LEN_BYTES   = 7'd4;

  typedef enum logic [1:0] {
    KIND_INTEGER = 2'd0,
    KIND_BOOLEAN = 2'd1,
    KIND_NULL    = 2'd2,
    KIND_OCTETS  = 2'd3
  } value_kind_e;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_INSUFFICIENT    = 3'd1,
    ST_TAG_MISMATCH    = 3'd2,
    ST_LEN_MISMATCH    = 3'd3,
    ST_LEN_UNSUPPORTED = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN1 = 4'b0010,
    PH_LEN2 = 4'b0100,
    PH_DATA = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [31:0] expected_tag;
    value_kind_e value_kind;
    logic [15:0] max_octets;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic        element_done;
    logic [63:0] decoded_value;
    logic [7:0]  content_byte;
    logic        content_valid;
    logic [15:0] content_index;
    logic [30:0] element_length;
  } result_t;

endpackage

`default_nettype wire

>>> src/btlv_apb_regs.sv
// APB register block of the BER TLV decoder: expected tag, value kind, octet limit.
// Depends on btlv_pkg for the register map and the configuration struct.
`default_nettype none

module btlv_apb_regs import btlv_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_tag <= EXPECTED_TAG_RESET;
      cfg_q.value_kind   <= KIND_INTEGER;
      cfg_q.max_octets   <= MAX_OCTETS_RESET;
    end else if (wr_en) begin
      case (paddr)
        REG_EXPECTED_TAG: cfg_q.expected_tag <= pwdata;
        REG_VALUE_KIND:   cfg_q.value_kind   <= value_kind_e'(pwdata[1:0]);
        REG_MAX_OCTETS:   cfg_q.max_octets   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_EXPECTED_TAG: prdata = cfg_q.expected_tag;
      REG_VALUE_KIND:   prdata = {30'd0, cfg_q.value_kind};
      REG_MAX_OCTETS:   prdata = {16'd0, cfg_q.max_octets};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/btlv_decode.sv
// Decode stage of the BER TLV decoder: element state and the per-byte step.
// Depends on btlv_pkg; produces one result struct per processed byte.
`default_nettype none
`include "assert_macros.svh"

module btlv_decode import btlv_pkg::*; #(
  parameter int unsigned WORD_BYTES = 8,
  parameter int unsigned TAG_BYTES  = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_end_i,
  input  wire cfg_t       cfg_i,
  output result_t         res_o
);

  localparam int unsigned TagBits = 8 * TAG_BYTES;
  localparam logic [31:0] TagMask = 32'((64'd1 << TagBits) - 64'd1);

  phase_e      phase_q, phase_d;
  logic [31:0] tag_accum_q, tag_accum_d;
  logic [2:0]  tag_left_q, tag_left_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [31:0] len_accum_q, len_accum_d;
  logic [30:0] content_left_q, content_left_d;
  logic [63:0] value_accum_q, value_accum_d;
  logic [30:0] content_count_q, content_count_d;
  logic        err_hold_q, err_hold_d;

  logic [31:0] tag_masked;
  logic [1:0]  tag_size_m1;
  logic [31:0] prim_bit;

  function automatic logic [30:0] shown_length(input logic [31:0] len, input cfg_t cfg);
    logic [30:0] r;
    r = len[30:0];
    if (cfg.value_kind == KIND_OCTETS && len > {16'd0, cfg.max_octets}) begin
      r = {15'd0, cfg.max_octets};
    end
    return r;
  endfunction

  function automatic logic [63:0] sign_extend(input logic [63:0] v, input logic [31:0] nbytes);
    logic [63:0] r;
    r = v;
    for (int k = 1; k < 8; k++) begin
      if (nbytes == 32'(k) && v[8*k-1]) begin
        r = v | (~64'd0 << (8 * k));
      end
    end
    return r;
  endfunction

  assign tag_masked = cfg_i.expected_tag & TagMask;

  always_comb begin
    if (tag_masked[31:24] != 8'd0) begin
      tag_size_m1 = 2'd3;
    end else if (tag_masked[23:16] != 8'd0) begin
      tag_size_m1 = 2'd2;
    end else if (tag_masked[15:8] != 8'd0) begin
      tag_size_m1 = 2'd1;
    end else begin
      tag_size_m1 = 2'd0;
    end
  end

  assign prim_bit = {24'd0, CONSTRUCTED_BIT} << {tag_size_m1, 3'b000};

  always_comb begin
    logic [31:0] tag_acc_v;
    logic [2:0]  tag_left_v;
    logic [31:0] len_acc_v;
    logic [2:0]  len_left_v;
    logic [30:0] content_left_v;
    logic [63:0] value_acc_v;
    logic [6:0]  len_bytes;
    logic        done;
    logic        emit;
    logic        resolve;
    status_e     status;

    phase_d         = phase_q;
    tag_accum_d     = tag_accum_q;
    tag_left_d      = tag_left_q;
    len_left_d      = len_left_q;
    len_accum_d     = len_accum_q;
    content_left_d  = content_left_q;
    value_accum_d   = value_accum_q;
    content_count_d = content_count_q;
    err_hold_d      = err_hold_q;

    tag_acc_v      = tag_accum_q;
    tag_left_v     = tag_left_q;
    len_acc_v      = len_accum_q;
    len_left_v     = len_left_q;
    content_left_v = content_left_q;
    value_acc_v    = value_accum_q;
    len_bytes      = data_byte_i[6:0] & LEN_FIELD_MASK[6:0];
    done           = 1'b0;
    emit           = 1'b0;
    resolve        = 1'b0;
    status         = ST_OK;
    res_o          = '0;

    if (step_i && err_hold_q) begin
      if (frame_end_i) begin
        err_hold_d = 1'b0;
        phase_d    = PH_TAG;
        tag_left_d = 3'd0;
      end
    end else if (step_i) begin
      case (phase_q)
        PH_TAG: begin
          if (tag_left_q == 3'd0) begin
            tag_acc_v  = {24'd0, data_byte_i};
            tag_left_v = {1'b0, tag_size_m1};
          end else begin
            tag_acc_v  = {tag_accum_q[23:0], data_byte_i};
            tag_left_v = tag_left_q - 3'd1;
          end
          tag_accum_d = tag_acc_v;
          tag_left_d  = tag_left_v;
          if (tag_left_v == 3'd0) begin
            if ((tag_masked | prim_bit) != (tag_acc_v | prim_bit)) begin
              status = ST_TAG_MISMATCH;
              done   = 1'b1;
            end else begin
              phase_d = PH_LEN1;
            end
          end
        end
        PH_LEN1: begin
          if ((data_byte_i & LONG_FORM_BIT) == 8'd0) begin
            len_acc_v   = {25'd0, len_bytes};
            len_accum_d = len_acc_v;
            resolve     = 1'b1;
          end else if (len_bytes == 7'd0 || len_bytes > MAX_LEN_BYTES) begin
            status = ST_LEN_UNSUPPORTED;
            done   = 1'b1;
          end else begin
            len_left_d  = len_bytes[2:0];
            len_accum_d = 32'd0;
            phase_d     = PH_LEN2;
          end
        end
        PH_LEN2: begin
          len_acc_v   = {len_accum_q[23:0], data_byte_i};
          len_left_v  = len_left_q - 3'd1;
          len_accum_d = len_acc_v;
          len_left_d  = len_left_v;
          if (len_left_v == 3'd0) begin
            if (len_acc_v[31]) begin
              status = ST_LEN_UNSUPPORTED;
              done   = 1'b1;
            end else begin
              resolve = 1'b1;
            end
          end
        end
        PH_DATA: begin
          res_o.element_length = shown_length(len_accum_q, cfg_i);
          if (cfg_i.value_kind == KIND_INTEGER) begin
            value_acc_v = {value_accum_q[55:0], data_byte_i};
          end else if (cfg_i.value_kind == KIND_BOOLEAN) begin
            value_acc_v = {56'd0, data_byte_i};
          end else if (cfg_i.value_kind == KIND_OCTETS &&
                       content_count_q < {15'd0, cfg_i.max_octets}) begin
            res_o.content_valid = 1'b1;
            res_o.content_byte  = data_byte_i;
            res_o.content_index = content_count_q[15:0];
            emit                = 1'b1;
          end
          value_accum_d   = value_acc_v;
          content_count_d = content_count_q + 31'd1;
          content_left_v  = content_left_q - 31'd1;
          content_left_d  = content_left_v;
          if (content_left_v == 31'd0) begin
            done = 1'b1;
            if (cfg_i.value_kind == KIND_INTEGER) begin
              res_o.decoded_value = sign_extend(value_acc_v, len_accum_q);
            end else if (cfg_i.value_kind == KIND_BOOLEAN) begin
              res_o.decoded_value = {56'd0, value_acc_v[7:0]};
            end
          end
        end
        default: begin
        end
      endcase

      if (resolve) begin
        res_o.element_length = shown_length(len_acc_v, cfg_i);
        content_count_d      = 31'd0;
        content_left_d       = len_acc_v[30:0];
        value_accum_d        = 64'd0;
        phase_d              = PH_DATA;
        case (cfg_i.value_kind)
          KIND_INTEGER: begin
            if (len_acc_v == 32'd0) begin
              status = ST_LEN_MISMATCH;
              done   = 1'b1;
            end else if (len_acc_v > 32'(WORD_BYTES)) begin
              status = ST_LEN_UNSUPPORTED;
              done   = 1'b1;
            end
          end
          KIND_BOOLEAN: begin
            if (len_acc_v != 32'd1) begin
              status = ST_LEN_MISMATCH;
              done   = 1'b1;
            end
          end
          KIND_NULL: begin
            if (len_acc_v != 32'd0) begin
              status = ST_LEN_MISMATCH;
            end
            done = 1'b1;
          end
          default: begin
            if (len_acc_v == 32'd0) begin
              done = 1'b1;
            end
          end
        endcase
      end

      if (!done && frame_end_i) begin
        status              = ST_INSUFFICIENT;
        done                = 1'b1;
        res_o.decoded_value = 64'd0;
      end

      if (done) begin
        emit       = 1'b1;
        phase_d    = PH_TAG;
        tag_left_d = 3'd0;
        if (status != ST_OK) begin
          res_o.decoded_value = 64'd0;
          err_hold_d          = !frame_end_i;
        end
      end

      res_o.valid        = emit;
      res_o.status       = status;
      res_o.element_done = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_TAG;
      tag_accum_q     <= 32'd0;
      tag_left_q      <= 3'd0;
      len_left_q      <= 3'd0;
      len_accum_q     <= 32'd0;
      content_left_q  <= 31'd0;
      value_accum_q   <= 64'd0;
      content_count_q <= 31'd0;
      err_hold_q      <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      tag_accum_q     <= tag_accum_d;
      tag_left_q      <= tag_left_d;
      len_left_q      <= len_left_d;
      len_accum_q     <= len_accum_d;
      content_left_q  <= content_left_d;
      value_accum_q   <= value_accum_d;
      content_count_q <= content_count_d;
      err_hold_q      <= err_hold_d;
    end
  end

  `ASSERT_RST(a_hold_is_silent, (step_i && err_hold_q) |-> !res_o.valid, "result while dropping bytes")
  `ASSERT_NEXT(a_fail_enters_hold, step_i && res_o.valid && res_o.status != ST_OK && !frame_end_i, err_hold_q, "failure mid-frame did not start dropping")
  `ASSERT_RST(a_phase_onehot, $onehot(phase_q), "phase register lost its one-hot code")

endmodule

`default_nettype wire

>>> src/ber_tlv_primitive_decoder.sv
// BER TLV primitive decoder, top level: input register, decode stage, result register.
// An accepted byte is held in the input register, its result in the result register.
// Throughput is one byte per cycle, bytes with no result too, unless the output stalls.
// Reset clears the element state and the handshake; registers return to tag 2,
// integer kind and an octet limit of 256.
// Depends on btlv_pkg, btlv_apb_regs and btlv_decode.
`default_nettype none
`include "assert_macros.svh"

module ber_tlv_primitive_decoder import btlv_pkg::*; #(
  parameter int unsigned WORD_BYTES = 8,
  parameter int unsigned TAG_BYTES  = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                frame_end_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [2:0]               status_o,
  output logic                     element_done_o,
  output logic signed [63:0]       decoded_value_o,
  output logic [7:0]               content_byte_o,
  output logic                     content_valid_o,
  output logic [15:0]              content_index_o,
  output logic [30:0]              element_length_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  cfg_t    cfg;
  result_t res;
  result_t out_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_fend_q;
  logic       out_valid_q;
  logic       step_en;
  logic       in_accept;

  btlv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  btlv_decode #(
    .WORD_BYTES (WORD_BYTES),
    .TAG_BYTES  (TAG_BYTES)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_en),
    .data_byte_i (in_byte_q),
    .frame_end_i (in_fend_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  assign step_en    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step_en;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step_en) begin
        in_valid_q <= 1'b0;
      end
      if (step_en && res.valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_fend_q <= frame_end_i;
    end
    if (step_en && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign element_done_o   = out_q.element_done;
  assign decoded_value_o  = $signed(out_q.decoded_value);
  assign content_byte_o   = out_q.content_byte;
  assign content_valid_o  = out_q.content_valid;
  assign content_index_o  = out_q.content_index;
  assign element_length_o = out_q.element_length;

  `ASSERT_RST(a_out_has_cause, out_valid_o |-> (element_done_o || content_valid_o), "result without cause")
  `ASSERT_RST(a_value_only_ok, (out_valid_o && decoded_value_o != 64'sd0) |-> (element_done_o && status_o == ST_OK), "value on unfinished or failed element")
  `ASSERT_RST(a_content_status, (out_valid_o && content_valid_o) |-> (status_o == ST_OK || status_o == ST_INSUFFICIENT), "content byte with a decode failure")

endmodule

`default_nettype wire
